// ----- design/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the text chunk splitter.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int MAX_PART_LEN = 4096;
  localparam int MAX_DIVIDERS = 4;
  localparam int DIV_SLOTS    = 4;   // divider bytes carried by the register
  localparam int WIN_DEPTH    = 6;

  localparam int LEN_W   = 13;
  localparam int DIVC_W  = 3;
  localparam int CNT_W   = 3;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_PART_LENGTH = 2'd0;
  localparam logic [1:0] REG_DIVIDER_CHARS   = 2'd1;
  localparam logic [1:0] REG_DIVIDER_COUNT   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       part_end;
    logic       message_end;
  } out_item_t;

endpackage

// ----- design/text_chunk_splitter.sv -----
// ----------------------------------------------------------------------------
// text_chunk_splitter
// Passes message text bytes through and marks where each speech part ends.
// ----------------------------------------------------------------------------
// Usage:
//   text_valid/text_stall/text_item carry one message byte and its last flag.
//   chunk_valid/chunk_stall/chunk_item carry each released byte with its
//   part_end and message_end marks. cfg_valid/cfg_ready/cfg_index/cfg_data
//   write max_part_length (0), divider_chars (1) and divider_count (2);
//   cfg_ready is always high; writes must go in while the block is idle,
//   which the block itself does not enforce. Up to six bytes sit in a
//   lookahead window. In steady flow, while the receiver does not stall, one
//   byte is taken and one released per cycle: the result shows in the cycle
//   after the transfer of the byte that pushes it out of the window.
//   A transfer with last starts a flush: the window (1 to 6 bytes) drains one
//   byte per cycle while the receiver does not stall, and text_stall stays
//   high until the last byte is loaded into the output register.
//   Throughput is set by the single output register: one result per cycle,
//   unless the receiver stalls; then the output register holds and text_stall
//   rises in the same cycle, so nothing is lost.
//   Reset (rst, synchronous) empties the window, clears the part length and
//   output valid, and loads the register reset values.
// ----------------------------------------------------------------------------
module text_chunk_splitter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  tcs_pkg::in_item_t    text_item,
  output logic                 chunk_valid,
  input  logic                 chunk_stall,
  output tcs_pkg::out_item_t   chunk_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  // configuration
  logic [tcs_pkg::LEN_W-1:0]  max_part_length;
  logic [31:0]                divider_chars;
  logic [tcs_pkg::DIVC_W-1:0] divider_count;

  // window and control
  logic [7:0]                 win [tcs_pkg::WIN_DEPTH];
  logic [tcs_pkg::CNT_W-1:0]  count;       // bytes held, 0..6
  logic                       flushing;
  logic [tcs_pkg::LEN_W-1:0]  part_length;

  logic                       out_free;
  logic                       text_take;
  logic                       release_norm;
  logic                       release_flush;
  logic                       do_release;

  logic [7:0]                 view [4];    // released byte and three after it
  logic [tcs_pkg::CNT_W-1:0]  follow;
  logic                       final_byte;

  logic [tcs_pkg::LEN_W-1:0]  eff_max;
  logic [tcs_pkg::DIVC_W-1:0] eff_divc;
  logic                       is_div;
  logic                       nx_blank;
  logic                       split_text;
  logic [tcs_pkg::LEN_W-1:0]  part_length_inc;
  logic                       split;

  assign cfg_ready = 1'b1;

  // output register is free when empty or being drained this cycle
  assign out_free   = !chunk_valid || !chunk_stall;
  assign text_stall = flushing || !out_free;
  assign text_take  = text_valid && !text_stall;

  // steady flow: the sixth byte pushes the oldest one out
  assign release_norm  = text_take && !text_item.last &&
                         (count == tcs_pkg::CNT_W'(tcs_pkg::WIN_DEPTH - 1));
  assign release_flush = flushing && out_free;
  assign do_release    = release_norm || release_flush;

  // view of the byte being released: slot 0 plus its successors; in steady
  // flow the incoming byte sits behind the five held ones
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      view[i] = win[i];
    end
    if (flushing) begin
      follow     = count - tcs_pkg::CNT_W'(1);
      final_byte = (count == tcs_pkg::CNT_W'(1));
    end else begin
      follow     = tcs_pkg::CNT_W'(tcs_pkg::WIN_DEPTH - 1);
      final_byte = 1'b0;
    end
  end

  // effective limits
  always_comb begin
    if (max_part_length == '0) begin
      eff_max = tcs_pkg::LEN_W'(1);
    end else if (max_part_length > tcs_pkg::LEN_W'(tcs_pkg::MAX_PART_LEN)) begin
      eff_max = tcs_pkg::LEN_W'(tcs_pkg::MAX_PART_LEN);
    end else begin
      eff_max = max_part_length;
    end
    eff_divc = divider_count;
    if (eff_divc > tcs_pkg::DIVC_W'(tcs_pkg::MAX_DIVIDERS)) begin
      eff_divc = tcs_pkg::DIVC_W'(tcs_pkg::MAX_DIVIDERS);
    end
    if (eff_divc > tcs_pkg::DIVC_W'(tcs_pkg::DIV_SLOTS)) begin
      eff_divc = tcs_pkg::DIVC_W'(tcs_pkg::DIV_SLOTS);
    end
  end

  // divider match; a zero divider slot never matches
  always_comb begin
    is_div = 1'b0;
    for (int k = 0; k < tcs_pkg::DIV_SLOTS; k++) begin
      if ((tcs_pkg::DIVC_W'(k) < eff_divc) && (divider_chars[8*k +: 8] != 8'h00) &&
          (divider_chars[8*k +: 8] == view[0])) begin
        is_div = 1'b1;
      end
    end
  end

  // text rules: divider or LF-LF need three bytes behind, CR LF CR LF five
  always_comb begin
    nx_blank   = (view[1] == tcs_pkg::CH_SPACE) || (view[1] == tcs_pkg::CH_LF) ||
                 (view[1] == tcs_pkg::CH_CR);
    split_text = 1'b0;
    if ((follow >= tcs_pkg::CNT_W'(3)) && nx_blank) begin
      if (is_div) begin
        split_text = 1'b1;
      end
      if ((view[0] == tcs_pkg::CH_LF) && (view[1] == tcs_pkg::CH_LF)) begin
        split_text = 1'b1;
      end
      if ((follow >= tcs_pkg::CNT_W'(5)) && (view[0] == tcs_pkg::CH_CR) &&
          (view[1] == tcs_pkg::CH_LF) && (view[2] == tcs_pkg::CH_CR) &&
          (view[3] == tcs_pkg::CH_LF)) begin
        split_text = 1'b1;
      end
    end
  end

  // length rule and message end
  assign part_length_inc = part_length + tcs_pkg::LEN_W'(1);
  assign split = split_text || (part_length_inc >= eff_max) || final_byte;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_part_length <= tcs_pkg::LEN_W'(256);
      divider_chars   <= '0;
      divider_count   <= '0;
      count           <= '0;
      flushing        <= 1'b0;
      part_length     <= '0;
      chunk_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcs_pkg::REG_MAX_PART_LENGTH: max_part_length <= cfg_data[tcs_pkg::LEN_W-1:0];
          tcs_pkg::REG_DIVIDER_CHARS:   divider_chars   <= cfg_data;
          tcs_pkg::REG_DIVIDER_COUNT:   divider_count   <= cfg_data[tcs_pkg::DIVC_W-1:0];
          default: ;
        endcase
      end

      if (do_release) begin
        chunk_valid <= 1'b1;
        part_length <= split ? '0 : part_length_inc;
      end else if (!chunk_stall) begin
        chunk_valid <= 1'b0;
      end

      if (release_flush) begin
        count <= count - tcs_pkg::CNT_W'(1);
        if (count == tcs_pkg::CNT_W'(1)) begin
          flushing <= 1'b0;
        end
      end else if (text_take) begin
        if (text_item.last) begin
          count    <= count + tcs_pkg::CNT_W'(1);
          flushing <= 1'b1;
        end else if (!release_norm) begin
          count <= count + tcs_pkg::CNT_W'(1);
        end
      end
    end
  end

  // window and output payload
  always_ff @(posedge clk) begin
    if (do_release) begin
      chunk_item.out_byte    <= view[0];
      chunk_item.part_end    <= split;
      chunk_item.message_end <= final_byte;
    end

    if (release_flush) begin
      for (int i = 0; i < tcs_pkg::WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
    end else if (release_norm) begin
      for (int i = 0; i < tcs_pkg::WIN_DEPTH - 2; i++) begin
        win[i] <= win[i+1];
      end
      win[tcs_pkg::WIN_DEPTH-2] <= text_item.in_byte;
    end else if (text_take) begin
      win[count] <= text_item.in_byte;
    end
  end

endmodule

// ----- design/tcs_checker.sv -----
// ----------------------------------------------------------------------------
// tcs_checker
// Port-level checks for the text chunk splitter, bound to the top level.
// ----------------------------------------------------------------------------
module tcs_checker (
  input logic                clk,
  input logic                rst,
  input logic                text_valid,
  input logic                text_stall,
  input tcs_pkg::in_item_t   text_item,
  input logic                chunk_valid,
  input logic                chunk_stall,
  input tcs_pkg::out_item_t  chunk_item
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !chunk_valid)
    else $error("chunk_valid high after reset");

  // the message end always closes a part
  a_msg_end_splits: assert property (@(posedge clk) disable iff (rst)
    (chunk_valid && chunk_item.message_end) |-> chunk_item.part_end)
    else $error("message end without part end");

  // a final byte starts the flush, so the next byte must wait
  a_flush_stalls: assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall && text_item.last) |=> text_stall)
    else $error("input taken during flush");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (chunk_valid && chunk_stall) |=> (chunk_valid && $stable(chunk_item)))
    else $error("stalled result changed");

endmodule

bind text_chunk_splitter tcs_checker u_tcs_checker (.*);

// ----- tb/sv/tb_text_chunk_splitter.sv -----
// ----------------------------------------------------------------------------
// tb_text_chunk_splitter
// Self-checking bench for the text chunk splitter. A tracker class keeps its
// own window, part counter and register copy, predicts every released byte
// with its part and message marks, and checks the block's output against it.
// Directed messages hit each split rule and its end-of-message guard, then
// random messages run under changing settings, sender gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_text_chunk_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  // index outside the register map, writes to it must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_BYTES = 240;
  // flush is at most six bytes, one per cycle when the output does not stall; a little margin on top
  localparam int DRAIN_CYCLES = 10;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // --------------------------------------------------------------------------
  // Tracker: predicted chunk bytes for every accepted text byte
  // --------------------------------------------------------------------------
  class split_tracker;
    logic [tcs_pkg::LEN_W-1:0]  max_len;
    logic [31:0]                div_chars;
    logic [tcs_pkg::DIVC_W-1:0] div_count;
    logic [7:0]                 window [tcs_pkg::WIN_DEPTH];
    int unsigned                held;
    int unsigned                part_len;
    tcs_pkg::out_item_t         owed_chunks [$];
    int unsigned                mismatches;
    int unsigned                checked;
    int unsigned                part_ends;

    function new();
      max_len    = 13'd256;
      div_chars  = '0;
      div_count  = '0;
      held       = 0;
      part_len   = 0;
      mismatches = 0;
      checked    = 0;
      part_ends  = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        tcs_pkg::REG_MAX_PART_LENGTH: max_len = data[tcs_pkg::LEN_W-1:0];
        tcs_pkg::REG_DIVIDER_CHARS:   div_chars = data;
        tcs_pkg::REG_DIVIDER_COUNT:   div_count = data[tcs_pkg::DIVC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned len_limit();
      int unsigned m;
      m = max_len;
      if (m == 0) m = 1;
      if (m > tcs_pkg::MAX_PART_LEN) m = tcs_pkg::MAX_PART_LEN;
      return m;
    endfunction

    function bit is_divider(logic [7:0] b);
      int unsigned n;
      n = div_count;
      if (n > tcs_pkg::MAX_DIVIDERS) n = tcs_pkg::MAX_DIVIDERS;
      if (n > tcs_pkg::DIV_SLOTS) n = tcs_pkg::DIV_SLOTS;
      for (int k = 0; k < n; k++)
        if (div_chars[8*k +: 8] != 8'h00 && div_chars[8*k +: 8] == b) return 1'b1;
      return 1'b0;
    endfunction

    // release one window slot; count is how many slots are filled
    function void release_slot(int unsigned idx, int unsigned count, bit fin);
      tcs_pkg::out_item_t r;
      int unsigned        follow;
      logic [7:0]         cur;
      logic [7:0]         nx;
      bit                 split;
      cur    = window[idx];
      follow = count - 1 - idx;
      split  = 1'b0;
      if (follow >= 3) begin
        nx = window[idx+1];
        if (nx == tcs_pkg::CH_SPACE || nx == tcs_pkg::CH_LF || nx == tcs_pkg::CH_CR) begin
          if (is_divider(cur)) split = 1'b1;
          if (cur == tcs_pkg::CH_LF && nx == tcs_pkg::CH_LF) split = 1'b1;
          if (follow >= 5 && cur == tcs_pkg::CH_CR && nx == tcs_pkg::CH_LF &&
              window[idx+2] == tcs_pkg::CH_CR && window[idx+3] == tcs_pkg::CH_LF)
            split = 1'b1;
        end
      end
      part_len++;
      if (part_len >= len_limit()) split = 1'b1;
      if (fin) split = 1'b1;
      if (split) part_len = 0;
      r.out_byte    = cur;
      r.part_end    = split;
      r.message_end = fin;
      owed_chunks.push_back(r);
    endfunction

    function void take_text(tcs_pkg::in_item_t it);
      int unsigned count;
      window[held] = it.in_byte;
      count = held + 1;
      if (it.last) begin
        for (int unsigned k = 0; k < count; k++) release_slot(k, count, k == count - 1);
        held     = 0;
        part_len = 0;
        foreach (window[i]) window[i] = '0;
      end else if (count < tcs_pkg::WIN_DEPTH) begin
        held = count;
      end else begin
        release_slot(0, count, 1'b0);
        for (int k = 0; k < tcs_pkg::WIN_DEPTH - 1; k++) window[k] = window[k+1];
        window[tcs_pkg::WIN_DEPTH-1] = '0;
        held = tcs_pkg::WIN_DEPTH - 1;
      end
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    function void match_chunk(tcs_pkg::out_item_t got);
      tcs_pkg::out_item_t want;
      checked++;
      if (got.part_end) part_ends++;
      if (owed_chunks.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h part_end %0b message_end %0b",
                               got.out_byte, got.part_end, got.message_end));
        return;
      end
      want = owed_chunks.pop_front();
      if (got.out_byte !== want.out_byte || got.part_end !== want.part_end ||
          got.message_end !== want.message_end)
        note_failure($sformatf({"chunk %0d: expected byte %02h part_end %0b ",
                                "message_end %0b, got byte %02h part_end %0b message_end %0b"},
                               checked, want.out_byte, want.part_end, want.message_end,
                               got.out_byte, got.part_end, got.message_end));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               text_valid;
  logic               text_stall;
  tcs_pkg::in_item_t  text_item;
  logic               chunk_valid;
  logic               chunk_stall;
  tcs_pkg::out_item_t chunk_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  text_chunk_splitter DUT (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_item   (text_item),
    .chunk_valid (chunk_valid),
    .chunk_stall (chunk_stall),
    .chunk_item  (chunk_item),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  split_tracker tracker;
  logic [7:0]   msg_bytes [$];   // message being sent
  bit           no_gaps;         // whole message goes back to back
  int unsigned  bytes_sent;
  int unsigned  messages_sent;
  int unsigned  cfg_writes;
  int unsigned  settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("text_chunk_splitter test failed");
    $finish;
  end

  // Output stalls: stretches of one flavor at a time. No stall at all, light
  // random stall, heavy random stall, or rare long holds.
  initial begin
    int mode;
    int span;
    chunk_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: chunk_stall <= 1'b0;
          1: chunk_stall <= ($urandom_range(0, 99) < 30);
          2: chunk_stall <= ($urandom_range(0, 99) < 70);
          default: begin
            if ($urandom_range(0, 99) < 6) begin
              chunk_stall <= 1'b1;
              repeat ($urandom_range(8, 30)) @(negedge clk);
              chunk_stall <= 1'b0;
            end else begin
              chunk_stall <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  // every output transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && chunk_valid && !chunk_stall) tracker.match_chunk(chunk_item);
  end

  // --------------------------------------------------------------------------
  // Drivers. All of them start and end on a falling edge.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One text transfer, then an optional idle gap. Valid stays high when the
  // next byte follows right away.
  task automatic push_text(input logic [7:0] b, input logic lst);
    tcs_pkg::in_item_t it;
    int                gap;
    it.in_byte = b;
    it.last    = lst;
    text_item  <= it;
    text_valid <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    tracker.take_text(it);
    bytes_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Sender goes quiet until the block owes nothing, then lets the flush
  // logic settle. Used before any register write.
  task automatic hold_until_drained();
    text_valid <= 1'b0;
    while (tracker.owed_chunks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // cfg_valid is left high; the caller drops it after the last write
  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  // full register update while idle; the stray index write must be ignored
  task automatic set_registers(input logic [31:0] len, input logic [31:0] chars,
                               input logic [31:0] cnt);
    hold_until_drained();
    write_cfg(REG_SPARE, $urandom);
    write_cfg(tcs_pkg::REG_MAX_PART_LENGTH, len);
    write_cfg(tcs_pkg::REG_DIVIDER_CHARS, chars);
    write_cfg(tcs_pkg::REG_DIVIDER_COUNT, cnt);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_divider();
    case ($urandom_range(0, 6))
      0: return CH_DOT;
      1: return 8'h2C;   // comma
      2: return 8'h3F;   // question mark
      3: return 8'h21;   // exclamation mark
      4: return 8'h3B;   // semicolon
      5: return 8'h00;   // empty slot
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_settings();
    logic [31:0] len;
    logic [31:0] chars;
    if ($urandom_range(0, 9) < 8) len = $urandom_range(0, 24);
    else len = $urandom_range(0, 8191);
    chars = {pick_divider(), pick_divider(), pick_divider(), pick_divider()};
    set_registers(len, chars, $urandom_range(0, 7));
  endtask

  // fixed corners first: length 0, 1, 2, top and beyond, counts past four,
  // all-ones and all-zero divider words, zero slots among live ones
  task automatic corner_settings(input int k);
    case (k)
      0: set_registers(1, 32'h212C_3F2E, 4);
      1: set_registers(0, 32'h212C_3F2E, 7);
      2: set_registers(8191, 32'hFFFF_FFFF, 5);
      3: set_registers(2, 32'h0000_002E, 1);
      4: set_registers(4096, 32'h0000_0000, 0);
      5: set_registers(3, 32'h3B3A_2C2E, 3);
      6: set_registers(5, 32'h2100_3F2E, 4);
      default: set_registers(4097, 32'h2E00_0000, 4);
    endcase
  endtask

  // text mix that favors the bytes the split rules look at
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 50) return tcs_pkg::CH_SPACE;
    if (r < 58) return tcs_pkg::CH_LF;
    if (r < 66) return tcs_pkg::CH_CR;
    if (r < 82) return tracker.div_chars[8*$urandom_range(0, 3) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_message();
    int len;
    int r;
    msg_bytes.delete();
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 10);
    else if (r < 92) len = $urandom_range(11, 30);
    else len = $urandom_range(31, 70);
    while (msg_bytes.size() < len) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        msg_bytes.push_back(tcs_pkg::CH_CR);
        msg_bytes.push_back(tcs_pkg::CH_LF);
        msg_bytes.push_back(tcs_pkg::CH_CR);
        msg_bytes.push_back(tcs_pkg::CH_LF);
      end else if (r < 12) begin
        msg_bytes.push_back(tcs_pkg::CH_LF);
        msg_bytes.push_back(tcs_pkg::CH_LF);
      end else if (r < 20) begin
        msg_bytes.push_back(tracker.div_chars[8*$urandom_range(0, 3) +: 8]);
        msg_bytes.push_back(tcs_pkg::CH_SPACE);
      end else begin
        msg_bytes.push_back(pick_char());
      end
    end
  endtask

  // Sends msg_bytes, last flag on the final byte. With pauses allowed, the
  // sender sometimes stops mid-message until the block has drained, and may
  // rewrite the registers there while bytes still sit in the window.
  task automatic send_message(input bit allow_pause);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      if (allow_pause && i > 0 && $urandom_range(0, 99) < 3) begin
        hold_until_drained();
        if ($urandom_range(0, 1)) random_settings();
      end
      push_text(msg_bytes[i], i == msg_bytes.size() - 1);
    end
    messages_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    int          corner;
    rst           = 1'b1;
    text_valid    = 1'b0;
    text_item     = '0;
    cfg_valid     = 1'b0;
    cfg_index     = tcs_pkg::REG_MAX_PART_LENGTH;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    bytes_sent    = 0;
    messages_sent = 0;
    cfg_writes    = 0;
    settings_used = 0;
    tracker       = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // dividers '.', ',' and '!' with an empty slot between them
    set_registers(256, 32'h2100_2C2E, 4);

    // divider then space, then LF LF, both far enough from the end
    msg_bytes = '{CH_DOT, tcs_pkg::CH_SPACE, tcs_pkg::CH_LF, tcs_pkg::CH_LF,
                  8'h61, 8'h62, 8'h63};
    send_message(1'b0);
    // CR LF CR LF with exactly five bytes behind the CR
    msg_bytes = '{tcs_pkg::CH_CR, tcs_pkg::CH_LF, tcs_pkg::CH_CR, tcs_pkg::CH_LF,
                  8'h61, 8'h62};
    send_message(1'b0);
    // zero text byte against the empty slot, divider too close to the end
    msg_bytes = '{8'h00, tcs_pkg::CH_SPACE, 8'h78, CH_DOT, tcs_pkg::CH_LF};
    send_message(1'b0);
    // one-byte message, all bits set
    msg_bytes = '{8'hFF};
    send_message(1'b0);

    // limit lowered mid-part to the length already reached: the part
    // must close after the next released byte
    for (int i = 0; i < 7; i++) push_text(8'(8'h61 + i), 1'b0);
    set_registers(2, 32'h2100_2C2E, 4);
    push_text(8'h68, 1'b1);
    messages_sent++;

    // random messages; corner settings are walked first, then random ones
    random_start = bytes_sent;
    corner = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (corner < 8) begin
        corner_settings(corner);
        corner++;
      end else if ($urandom_range(0, 99) < 30) begin
        random_settings();
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      build_message();
      send_message(1'b1);
    end

    hold_until_drained();
    $display("Ran %0d messages, %0d text bytes; %0d released bytes checked, %0d part ends.",
             messages_sent, bytes_sent, tracker.checked, tracker.part_ends);
    $display("%0d register writes over %0d settings; %0d mismatches.",
             cfg_writes, settings_used, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.owed_chunks.size() == 0) begin
      $display("text_chunk_splitter test passed");
    end else begin
      $display("text_chunk_splitter test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tcs_pkg.sv
design/text_chunk_splitter.sv
design/tcs_checker.sv
tb/sv/tb_text_chunk_splitter.sv
